// File: rtl/core/hrc_pkg.sv
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and fixed-point constants for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hrc_pkg;

  // Field widths
  localparam int unsigned HUE_W      = 16;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned REM_W      = 13;  // remainder within one sector
  localparam int unsigned SPROD_W    = 21;  // saturation * remainder
  localparam int unsigned PV_W       = 16;  // value * (255 - saturation)
  localparam int unsigned SCALED_W   = 29;  // value * (D - S*r)
  localparam int unsigned DIV_IN_W   = 20;  // scaled product after >> 9
  localparam int unsigned RECIP_W    = 21;
  localparam int unsigned RPROD_W    = DIV_IN_W + RECIP_W;

  // Hue geometry: one turn is 360 * 128, one sector 60 * 128
  localparam logic [HUE_W-1:0]  HUE_TURN   = 16'd46080;
  localparam logic [HUE_W-1:0]  HUE_SECTOR = 16'd7680;
  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

  // D = 255 * 7680 = 3825 * 2^9
  localparam logic [SPROD_W-1:0] DEN         = 21'd1958400;
  localparam int unsigned        DEN_SHIFT   = 9;
  localparam logic [11:0]        DEN_ODD     = 12'd3825;
  // floor(2^32 / 3825); estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP       = 21'd1122867;
  localparam int unsigned        RECIP_SHIFT = 32;

  // Six hue sectors
  typedef enum logic [2:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } hrc_sect_t;

  // Port payloads
  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } hrc_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } hrc_out_t;

  // Between sector stage and product stages
  typedef struct packed {
    hrc_sect_t         sector;
    logic [REM_W-1:0]  rem;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] val;
  } hrc_sec_t;

  // Between product stages and divider stages
  typedef struct packed {
    hrc_sect_t           sector;
    logic [CHAN_W-1:0]   val;
    logic [CHAN_W-1:0]   p;
    logic [DIV_IN_W-1:0] zq;
    logic [DIV_IN_W-1:0] zt;
  } hrc_frac_t;

  // Between divider stages and output mux
  typedef struct packed {
    hrc_sect_t         sector;
    logic [CHAN_W-1:0] val;
    logic [CHAN_W-1:0] p;
    logic [CHAN_W-1:0] q;
    logic [CHAN_W-1:0] t;
  } hrc_chan_t;

  // Start of each sector in hue units
  function automatic logic [HUE_W-1:0] sector_base(input logic [2:0] idx);
    logic [HUE_W-1:0] base;
    unique case (idx)
      SECT_RED:     base = 16'd0;
      SECT_YELLOW:  base = 16'd7680;
      SECT_GREEN:   base = 16'd15360;
      SECT_CYAN:    base = 16'd23040;
      SECT_BLUE:    base = 16'd30720;
      SECT_MAGENTA: base = 16'd38400;
      default:      base = 16'd0;
    endcase
    return base;
  endfunction

endpackage

// File: rtl/core/hrc_sector.sv
// ----------------------------------------------------------------------------
// hrc_sector
// Stage 1: folds out-of-range hue to zero, finds the sector and remainder.
// ----------------------------------------------------------------------------
module hrc_sector (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  output logic             in_rdy,
  input  hrc_pkg::hrc_in_t in_data,
  output logic             out_vld,
  input  logic             out_rdy,
  output hrc_pkg::hrc_sec_t out_data
);

  logic                        vld_r;
  hrc_pkg::hrc_sec_t           data_r;
  hrc_pkg::hrc_sec_t           data_nxt;
  logic [hrc_pkg::HUE_W-1:0]   hue_c;
  logic [hrc_pkg::HUE_W-1:0]   rem_full;
  logic [2:0]                  cnt;

  assign in_rdy = !vld_r || out_rdy;

  // Sector = number of sector boundaries at or below the hue
  always_comb begin
    hue_c = (in_data.hue >= hrc_pkg::HUE_TURN) ? '0 : in_data.hue;
    cnt   = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (hue_c >= 16'(k) * hrc_pkg::HUE_SECTOR) begin
        cnt = cnt + 3'd1;
      end
    end
    rem_full        = hue_c - hrc_pkg::sector_base(cnt);
    data_nxt.sector = hrc_pkg::hrc_sect_t'(cnt);
    data_nxt.rem    = rem_full[hrc_pkg::REM_W-1:0];
    data_nxt.sat    = in_data.saturation;
    data_nxt.val    = in_data.brightness;
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// File: rtl/core/hrc_mult.sv
// ----------------------------------------------------------------------------
// hrc_mult
// Stages 2-3: saturation products, then value scaling and the p channel.
// ----------------------------------------------------------------------------
module hrc_mult (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  output logic               in_rdy,
  input  hrc_pkg::hrc_sec_t  in_data,
  output logic               out_vld,
  input  logic               out_rdy,
  output hrc_pkg::hrc_frac_t out_data
);

  typedef struct packed {
    hrc_pkg::hrc_sect_t              sector;
    logic [hrc_pkg::CHAN_W-1:0]      val;
    logic [hrc_pkg::PV_W-1:0]        pv;
    logic [hrc_pkg::SPROD_W-1:0]     srq;
    logic [hrc_pkg::SPROD_W-1:0]     srt;
  } prod_t;

  logic                          a_vld_r;
  logic                          b_vld_r;
  logic                          a_rdy;
  logic                          b_rdy;
  prod_t                         a_r;
  prod_t                         a_nxt;
  hrc_pkg::hrc_frac_t            b_r;
  hrc_pkg::hrc_frac_t            b_nxt;
  logic [hrc_pkg::REM_W-1:0]     rem_t;
  logic [hrc_pkg::SPROD_W-1:0]   nq;
  logic [hrc_pkg::SPROD_W-1:0]   nt;
  logic [hrc_pkg::SCALED_W-1:0]  yq;
  logic [hrc_pkg::SCALED_W-1:0]  yt;
  logic [hrc_pkg::PV_W:0]        psum;

  assign b_rdy  = !b_vld_r || out_rdy;
  assign a_rdy  = !a_vld_r || b_rdy;
  assign in_rdy = a_rdy;

  // Stage A: S*r, S*(7680-r), V*(255-S)
  always_comb begin
    rem_t        = hrc_pkg::HUE_SECTOR[hrc_pkg::REM_W-1:0] - in_data.rem;
    a_nxt.sector = in_data.sector;
    a_nxt.val    = in_data.val;
    a_nxt.srq    = 21'(in_data.sat) * 21'(in_data.rem);
    a_nxt.srt    = 21'(in_data.sat) * 21'(rem_t);
    a_nxt.pv     = 16'(in_data.val) * 16'(hrc_pkg::FULL_SCALE - in_data.sat);
  end

  // Stage B: V*(D - S*x) >> 9, p = pv / 255
  always_comb begin
    nq           = hrc_pkg::DEN - a_r.srq;
    nt           = hrc_pkg::DEN - a_r.srt;
    yq           = 29'(a_r.val) * 29'(nq);
    yt           = 29'(a_r.val) * 29'(nt);
    // exact x/255 for x up to 65025
    psum         = 17'(a_r.pv) + 17'(a_r.pv[15:8]) + 17'd1;
    b_nxt.sector = a_r.sector;
    b_nxt.val    = a_r.val;
    b_nxt.p      = psum[15:8];
    b_nxt.zq     = yq[hrc_pkg::DEN_SHIFT +: hrc_pkg::DIV_IN_W];
    b_nxt.zt     = yt[hrc_pkg::DEN_SHIFT +: hrc_pkg::DIV_IN_W];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= in_vld;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (a_rdy && in_vld) begin
      a_r <= a_nxt;
    end
    if (b_rdy && a_vld_r) begin
      b_r <= b_nxt;
    end
  end

  assign out_vld  = b_vld_r;
  assign out_data = b_r;

endmodule

// File: rtl/core/hrc_div.sv
// ----------------------------------------------------------------------------
// hrc_div
// Stages 4-5: divide q and t numerators by 3825 via reciprocal and fix-up.
// ----------------------------------------------------------------------------
module hrc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  output logic               in_rdy,
  input  hrc_pkg::hrc_frac_t in_data,
  output logic               out_vld,
  input  logic               out_rdy,
  output hrc_pkg::hrc_chan_t out_data
);

  typedef struct packed {
    hrc_pkg::hrc_sect_t            sector;
    logic [hrc_pkg::CHAN_W-1:0]    val;
    logic [hrc_pkg::CHAN_W-1:0]    p;
    logic [hrc_pkg::CHAN_W-1:0]    eq;
    logic [hrc_pkg::CHAN_W-1:0]    et;
    logic [hrc_pkg::DIV_IN_W-1:0]  zq;
    logic [hrc_pkg::DIV_IN_W-1:0]  zt;
  } est_t;

  logic                          a_vld_r;
  logic                          b_vld_r;
  logic                          a_rdy;
  logic                          b_rdy;
  est_t                          a_r;
  est_t                          a_nxt;
  hrc_pkg::hrc_chan_t            b_r;
  hrc_pkg::hrc_chan_t            b_nxt;
  logic [hrc_pkg::RPROD_W-1:0]   rq;
  logic [hrc_pkg::RPROD_W-1:0]   rt;
  logic [hrc_pkg::DIV_IN_W-1:0]  cq;
  logic [hrc_pkg::DIV_IN_W-1:0]  ct;
  logic [hrc_pkg::DIV_IN_W-1:0]  dq;
  logic [hrc_pkg::DIV_IN_W-1:0]  dt;

  assign b_rdy  = !b_vld_r || out_rdy;
  assign a_rdy  = !a_vld_r || b_rdy;
  assign in_rdy = a_rdy;

  // Stage A: quotient estimate, never above the true quotient
  always_comb begin
    rq           = 41'(in_data.zq) * 41'(hrc_pkg::RECIP);
    rt           = 41'(in_data.zt) * 41'(hrc_pkg::RECIP);
    a_nxt.sector = in_data.sector;
    a_nxt.val    = in_data.val;
    a_nxt.p      = in_data.p;
    a_nxt.eq     = rq[hrc_pkg::RECIP_SHIFT +: hrc_pkg::CHAN_W];
    a_nxt.et     = rt[hrc_pkg::RECIP_SHIFT +: hrc_pkg::CHAN_W];
    a_nxt.zq     = in_data.zq;
    a_nxt.zt     = in_data.zt;
  end

  // Stage B: bump estimate when the remainder reaches the divisor
  always_comb begin
    cq           = 20'(a_r.eq) * 20'(hrc_pkg::DEN_ODD);
    ct           = 20'(a_r.et) * 20'(hrc_pkg::DEN_ODD);
    dq           = a_r.zq - cq;
    dt           = a_r.zt - ct;
    b_nxt.sector = a_r.sector;
    b_nxt.val    = a_r.val;
    b_nxt.p      = a_r.p;
    b_nxt.q      = (dq >= 20'(hrc_pkg::DEN_ODD)) ? a_r.eq + 8'd1 : a_r.eq;
    b_nxt.t      = (dt >= 20'(hrc_pkg::DEN_ODD)) ? a_r.et + 8'd1 : a_r.et;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= in_vld;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (a_rdy && in_vld) begin
      a_r <= a_nxt;
    end
    if (b_rdy && a_vld_r) begin
      b_r <= b_nxt;
    end
  end

  assign out_vld  = b_vld_r;
  assign out_data = b_r;

endmodule

// File: rtl/core/hsv_to_rgb_converter_top.sv
// Pipeline: six register stages (sector, product A and B, divider A and B,
//   output register) carry each color from input transfer to out_valid.
// Throughput: one color per cycle while out_stall is low, set by the fully pipelined multipliers.
// Each stage holds its item under stall while emptier stages still fill.
// Reset (synchronous, rst_n low) clears every valid bit; no datapath state.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Pipelined HSV to 8-bit RGB converter with valid/stall handshakes.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hrc_pkg::hrc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hrc_pkg::hrc_out_t out_data
);

  logic               sec_in_rdy;
  logic               sec_vld;
  logic               sec_rdy;
  hrc_pkg::hrc_sec_t  sec_data;
  logic               frac_vld;
  logic               frac_rdy;
  hrc_pkg::hrc_frac_t frac_data;
  logic               chan_vld;
  logic               chan_rdy;
  hrc_pkg::hrc_chan_t chan_data;
  logic               out_vld_r;
  hrc_pkg::hrc_out_t  out_r;
  hrc_pkg::hrc_out_t  out_nxt;

  assign in_stall = !sec_in_rdy;

  hrc_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_valid),
    .in_rdy   (sec_in_rdy),
    .in_data  (in_data),
    .out_vld  (sec_vld),
    .out_rdy  (sec_rdy),
    .out_data (sec_data)
  );

  hrc_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sec_vld),
    .in_rdy   (sec_rdy),
    .in_data  (sec_data),
    .out_vld  (frac_vld),
    .out_rdy  (frac_rdy),
    .out_data (frac_data)
  );

  hrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (frac_vld),
    .in_rdy   (frac_rdy),
    .in_data  (frac_data),
    .out_vld  (chan_vld),
    .out_rdy  (chan_rdy),
    .out_data (chan_data)
  );

  assign chan_rdy = !out_vld_r || !out_stall;

  // Sector routing of V, p, q, t onto R, G, B
  always_comb begin
    unique case (chan_data.sector)
      hrc_pkg::SECT_RED: begin
        out_nxt = '{red: chan_data.val, green: chan_data.t, blue: chan_data.p};
      end
      hrc_pkg::SECT_YELLOW: begin
        out_nxt = '{red: chan_data.q, green: chan_data.val, blue: chan_data.p};
      end
      hrc_pkg::SECT_GREEN: begin
        out_nxt = '{red: chan_data.p, green: chan_data.val, blue: chan_data.t};
      end
      hrc_pkg::SECT_CYAN: begin
        out_nxt = '{red: chan_data.p, green: chan_data.q, blue: chan_data.val};
      end
      hrc_pkg::SECT_BLUE: begin
        out_nxt = '{red: chan_data.t, green: chan_data.p, blue: chan_data.val};
      end
      default: begin
        out_nxt = '{red: chan_data.val, green: chan_data.p, blue: chan_data.q};
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (chan_rdy) begin
      out_vld_r <= chan_vld;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (chan_rdy && chan_vld) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/hrc_checker.sv
// ----------------------------------------------------------------------------
// hrc_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hrc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input hrc_pkg::hrc_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input hrc_pkg::hrc_out_t out_data
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Free output means the whole pipeline can advance
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

  // Without output stall a transfer reaches out_valid through every register stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data == in_data) ##1 !out_stall ##1 !out_stall
      ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind hsv_to_rgb_converter_top hrc_checker u_hrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: test/hsv_to_rgb_converter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top_tb
// Drives HSV colors through the converter and compares every RGB transfer
// against a bit-exact fixed-point predictor kept in a small scoreboard.
// A directed set covers sector edges, hue wrap and grey. Random colors
// follow, with idle bursts on both channels and one long output hold-off
// that backs up the pipeline.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top_tb;
  import hrc_pkg::*;

  // Run shape
  localparam int unsigned RAND_ITEMS  = 1250;
  localparam int unsigned QUIET_ITEMS = 150;     // tail with no idling
  localparam int unsigned PRESSURE_AT = 400;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Hue geometry for the predictor
  localparam longint unsigned TURN_UNITS   = 46080;
  localparam longint unsigned SECTOR_UNITS = 7680;
  localparam longint unsigned SCALE        = 255;
  localparam longint unsigned SECTOR_DEN   = SCALE * SECTOR_UNITS;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the color for each input transfer, checks results
  // --------------------------------------------------------------------------
  class rgb_scoreboard;
    hrc_out_t    expected_rgb[$];
    int unsigned errors;
    int unsigned noted;
    int unsigned checked;

    function new();
      errors  = 0;
      noted   = 0;
      checked = 0;
    endfunction

    // Six-sector conversion, every division truncating
    function hrc_out_t predict_rgb(hrc_in_t c);
      hrc_out_t        rgb;
      longint unsigned h, s, v, rem, p, q, t;
      hrc_sect_t       sect;
      h = c.hue;
      s = c.saturation;
      v = c.brightness;
      if (s == 0) begin
        rgb.red   = v[7:0];
        rgb.green = v[7:0];
        rgb.blue  = v[7:0];
      end else begin
        if (h >= TURN_UNITS) h = 0;
        sect = hrc_sect_t'(3'(h / SECTOR_UNITS));
        rem  = h % SECTOR_UNITS;
        p    = (v * (SCALE - s)) / SCALE;
        q    = (v * (SECTOR_DEN - s * rem)) / SECTOR_DEN;
        t    = (v * (SECTOR_DEN - s * (SECTOR_UNITS - rem))) / SECTOR_DEN;
        case (sect)
          SECT_RED:    begin rgb.red = v[7:0]; rgb.green = t[7:0]; rgb.blue = p[7:0]; end
          SECT_YELLOW: begin rgb.red = q[7:0]; rgb.green = v[7:0]; rgb.blue = p[7:0]; end
          SECT_GREEN:  begin rgb.red = p[7:0]; rgb.green = v[7:0]; rgb.blue = t[7:0]; end
          SECT_CYAN:   begin rgb.red = p[7:0]; rgb.green = q[7:0]; rgb.blue = v[7:0]; end
          SECT_BLUE:   begin rgb.red = t[7:0]; rgb.green = p[7:0]; rgb.blue = v[7:0]; end
          default:     begin rgb.red = v[7:0]; rgb.green = p[7:0]; rgb.blue = q[7:0]; end
        endcase
      end
      return rgb;
    endfunction

    function void note_input(hrc_in_t c);
      expected_rgb.push_back(predict_rgb(c));
      noted++;
    endfunction

    function void check_chan(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(hrc_out_t got);
      hrc_out_t want;
      if (expected_rgb.size() == 0) begin
        errors++;
        $display("%0t: result with no transfer pending, expected none, actual %0d/%0d/%0d",
                 $time, got.red, got.green, got.blue);
      end else begin
        want = expected_rgb.pop_front();
        checked++;
        check_chan("red",   want.red,   got.red);
        check_chan("green", want.green, got.green);
        check_chan("blue",  want.blue,  got.blue);
      end
    endfunction
  endclass

  // DUT signals
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  hrc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hrc_out_t out_data;

  // Shared run control
  bit          quiet        = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned dense_left   = 0;
  int unsigned input_stalls = 0;
  int unsigned cycle_count  = 0;

  rgb_scoreboard sb = new();

  // Directed colors: sector edges, hue wrap, grey, channel extremes
  int unsigned dir_hue[24] = '{0, 0, 0, 65535, 7679, 7680, 15359, 15360, 23039, 23040,
                               30720, 38399, 38400, 46079, 46080, 65535, 3840, 11520,
                               19200, 26880, 34560, 42240, 1, 50000};
  int unsigned dir_sat[24] = '{255, 0, 0, 0, 255, 255, 255, 255, 255, 255,
                               255, 255, 255, 255, 255, 255, 128, 1,
                               255, 77, 200, 255, 254, 100};
  int unsigned dir_val[24] = '{255, 0, 255, 200, 255, 255, 255, 255, 255, 255,
                               255, 255, 255, 255, 255, 255, 200, 255,
                               1, 143, 90, 0, 255, 100};

  hsv_to_rgb_converter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, sb.expected_rgb.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (rst_n && in_valid && in_stall) input_stalls <= input_stalls + 1;
  end

  // Output stall: short random bursts, one long hold-off on request
  initial begin : out_stall_gen
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned hold_left;
    bit          s;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        s = 1'b1;
        hold_left--;
      end else if (quiet) begin
        s = 1'b0;
      end else if (stall_left > 0) begin
        s = 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        s = 1'b0;
        free_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        s = 1'b1;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        s = 1'b0;
        free_left = $urandom_range(0, 30);
      end
      out_stall <= s;
    end
  end

  // Offer one color, with an optional idle burst first; returns at the
  // edge where the transfer happened
  task automatic send_color(input hrc_in_t c);
    int unsigned gap;
    gap = 0;
    if (!quiet && dense_left == 0 && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    sb.note_input(c);
  endtask

  // Channel value biased toward the extremes
  function automatic logic [7:0] rand_chan();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return 8'd0;
    if (mode == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly in-range hues, some wrapped ones and some near sector edges
  function automatic hrc_in_t rand_color();
    hrc_in_t     c;
    int unsigned mode;
    int          base_pt;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      c.hue = 16'($urandom_range(0, 46079));
    end else if (mode == 6) begin
      c.hue = 16'($urandom_range(46080, 65535));
    end else if (mode == 7) begin
      c.hue = 16'($urandom);
    end else begin
      base_pt = 7680 * $urandom_range(0, 6) + $urandom_range(0, 4) - 2;
      c.hue = 16'(base_pt);
    end
    c.saturation = rand_chan();
    c.brightness = rand_chan();
    return c;
  endfunction

  // Stimulus and end of run
  initial begin : stimulus
    hrc_in_t c;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    for (int i = 0; i < 24; i++) begin
      c.hue        = 16'(dir_hue[i]);
      c.saturation = 8'(dir_sat[i]);
      c.brightness = 8'(dir_val[i]);
      send_color(c);
    end

    // Random part, with a back-to-back stretch during the long hold-off
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (i == PRESSURE_AT) begin
        hold_request = 1'b1;
        dense_left   = 60;
      end
      send_color(rand_color());
      if (dense_left > 0) dense_left--;
    end
    in_valid <= 1'b0;

    // Drain, then allow for any stray results
    while (sb.expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Summary: %0d colors sent, %0d results checked, %0d mismatches",
             sb.noted, sb.checked, sb.errors);
    $display("Covered sector edges, hue wrap, grey, %0d stalled input cycles",
             input_stalls);
    if (sb.errors == 0 && sb.expected_rgb.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
